FILE: design/pfq_pkg.sv
package pfq_pkg;

	// Fixed field widths of the request and result ports.
	localparam int REQ_W  = 2;
	localparam int PID_W  = 16;
	localparam int PAY_W  = 64;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RMV = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// Sequencer state codes.
	localparam logic [1:0] SEQ_IDLE = 2'd0;
	localparam logic [1:0] SEQ_EXEC = 2'd1;
	localparam logic [1:0] SEQ_DEQ  = 2'd2;
	localparam logic [1:0] SEQ_SCAN = 2'd3;

	typedef logic [STAT_W-1:0] status_t;
	typedef logic [REQ_W-1:0]  req_t;

endpackage

FILE: design/process_fifo_with_pid_removal_top.sv
// Channel   Handshake            Fields
// request   start / busy         req_type, proc_id, entry_payload
// result    done (one cycle)     status, out_id, out_payload, entry_count, not_empty
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe. Enqueue and the unused code end in the execute state;
// dequeue reads the head there and returns it from the dequeue state; remove-by-id
// makes one pass of the entry memory's read port over the queue.
// Reset empties the queue; the entry memory itself is not cleared. The receiver
// cannot stall.
module process_fifo_with_pid_removal_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pfq_pkg::REQ_W-1:0]     req_type,
	input  logic [pfq_pkg::PID_W-1:0]     proc_id,
	input  logic [pfq_pkg::PAY_W-1:0]     entry_payload,
	output logic                          done,
	output logic [pfq_pkg::STAT_W-1:0]    status,
	output logic [pfq_pkg::PID_W-1:0]     out_id,
	output logic [pfq_pkg::PAY_W-1:0]     out_payload,
	output logic [pfq_pkg::CNT_W-1:0]     entry_count,
	output logic                          not_empty
);
	import pfq_pkg::*;

	// Stored identifier width: the port width bounds what can be kept.
	localparam int SW = (ID_BITS < PID_W) ? ID_BITS : PID_W;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = SW + PAY_W;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;
	logic [SW-1:0] res_id;
	logic [OW-1:0] occupancy;

	// Queue sequencer.
	pfq_ctrl #(
		.DEPTH(QUEUE_DEPTH),
		.SW   (SW),
		.AW   (AW),
		.OW   (OW),
		.EW   (EW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.req_id     (proc_id[SW-1:0]),
		.req_payload(entry_payload),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.done       (done),
		.status     (status),
		.res_id     (res_id),
		.res_payload(out_payload),
		.occupancy  (occupancy)
	);

	// Entry memory.
	pfq_store #(
		.DEPTH(QUEUE_DEPTH),
		.EW   (EW),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign out_id      = PID_W'(res_id);
	assign entry_count = CNT_W'(occupancy);
	assign not_empty   = (occupancy != '0);

endmodule

FILE: design/pfq_store.sv
module pfq_store #(
	parameter int DEPTH = 16,
	parameter int EW    = 80,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	// Entry memory: identifier in the upper bits, payload in the lower bits.
	logic [EW-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/pfq_ctrl.sv
module pfq_ctrl #(
	parameter int DEPTH = 16,
	parameter int SW    = 16,
	parameter int AW    = 4,
	parameter int OW    = 5,
	parameter int EW    = 80
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  pfq_pkg::req_t          req_type,
	input  logic [SW-1:0]          req_id,
	input  logic [pfq_pkg::PAY_W-1:0] req_payload,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [EW-1:0]          mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  logic [EW-1:0]          mem_rdata,
	output logic                   done,
	output pfq_pkg::status_t       status,
	output logic [SW-1:0]          res_id,
	output logic [pfq_pkg::PAY_W-1:0] res_payload,
	output logic [OW-1:0]          occupancy
);
	import pfq_pkg::*;

	logic [1:0]       state_q;
	req_t             req_q;
	logic [SW-1:0]    pid_q;
	logic [PAY_W-1:0] pay_q;
	logic [AW-1:0]    head_q;
	logic [OW-1:0]    occ_q;
	logic [OW-1:0]    rp_q;
	logic             dvalid_s1;
	logic [OW-1:0]    dpos_s1;
	logic             found_q;
	logic             done_q;
	status_t          status_q;
	logic [SW-1:0]    res_id_q;
	logic [PAY_W-1:0] res_pay_q;
	logic             full;
	logic             more_reads;
	logic             id_match;

	// Physical slot of a queue position counted from the head.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
			input logic [OW-1:0] pos);
		logic [OW:0] sum;
		begin
			sum = (OW+1)'(head) + (OW+1)'(pos);
			if (sum >= (OW+1)'(DEPTH)) begin
				sum = sum - (OW+1)'(DEPTH);
			end
			return sum[AW-1:0];
		end
	endfunction

	assign full       = (occ_q >= OW'(DEPTH));
	assign more_reads = (rp_q < occ_q);
	assign id_match   = (mem_rdata[EW-1:PAY_W] == pid_q);

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_of(head_q, occ_q);
		mem_wdata = {pid_q, pay_q};
		mem_re    = 1'b0;
		mem_raddr = slot_of(head_q, rp_q);
		unique case (state_q)
			SEQ_EXEC: begin
				if (req_q == REQ_ENQ && !full) begin
					mem_we = 1'b1;
				end
				if (req_q == REQ_DEQ && occ_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
				end
			end
			SEQ_SCAN: begin
				mem_re = more_reads;
				// Once the match is taken out, each later entry moves up by one.
				if (dvalid_s1 && found_q) begin
					mem_we    = 1'b1;
					mem_waddr = slot_of(head_q, dpos_s1 - OW'(1));
					mem_wdata = mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req_type;
			pid_q <= req_id;
			pay_q <= req_payload;
		end
	end

	// Sequencer, queue pointers and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			head_q    <= '0;
			occ_q     <= '0;
			rp_q      <= '0;
			dvalid_s1 <= 1'b0;
			dpos_s1   <= '0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= STAT_DONE;
			res_id_q  <= '0;
			res_pay_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SEQ_IDLE: begin
					if (start) begin
						state_q <= SEQ_EXEC;
					end
				end
				SEQ_EXEC: begin
					res_id_q  <= '0;
					res_pay_q <= '0;
					unique case (req_q)
						REQ_ENQ: begin
							done_q  <= 1'b1;
							state_q <= SEQ_IDLE;
							if (full) begin
								status_q <= STAT_FULL;
							end else begin
								status_q <= STAT_DONE;
								occ_q    <= occ_q + OW'(1);
							end
						end
						REQ_DEQ: begin
							if (occ_q == '0) begin
								status_q <= STAT_MISS;
								done_q   <= 1'b1;
								state_q  <= SEQ_IDLE;
							end else begin
								state_q <= SEQ_DEQ;
							end
						end
						REQ_RMV: begin
							rp_q      <= '0;
							dvalid_s1 <= 1'b0;
							found_q   <= 1'b0;
							state_q   <= SEQ_SCAN;
						end
						REQ_NOP: begin
							status_q <= STAT_DONE;
							done_q   <= 1'b1;
							state_q  <= SEQ_IDLE;
						end
					endcase
				end
				SEQ_DEQ: begin
					res_id_q  <= mem_rdata[EW-1:PAY_W];
					res_pay_q <= mem_rdata[PAY_W-1:0];
					head_q    <= (32'(head_q) + 1 >= DEPTH) ? '0 : head_q + AW'(1);
					occ_q     <= occ_q - OW'(1);
					status_q  <= STAT_DONE;
					done_q    <= 1'b1;
					state_q   <= SEQ_IDLE;
				end
				SEQ_SCAN: begin
					// Read stream runs one position ahead of the compare.
					if (more_reads) begin
						rp_q      <= rp_q + OW'(1);
						dvalid_s1 <= 1'b1;
						dpos_s1   <= rp_q;
					end else begin
						dvalid_s1 <= 1'b0;
					end
					if (dvalid_s1 && !found_q && id_match) begin
						found_q   <= 1'b1;
						res_id_q  <= mem_rdata[EW-1:PAY_W];
						res_pay_q <= mem_rdata[PAY_W-1:0];
					end
					// All entries read and the last one handled.
					if (!more_reads && !dvalid_s1) begin
						done_q  <= 1'b1;
						state_q <= SEQ_IDLE;
						if (found_q) begin
							status_q <= STAT_DONE;
							occ_q    <= occ_q - OW'(1);
						end else begin
							status_q <= STAT_MISS;
						end
					end
				end
			endcase
		end
	end

	assign busy        = (state_q != SEQ_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign res_id      = res_id_q;
	assign res_payload = res_pay_q;
	assign occupancy   = occ_q;

endmodule
